/* rtl/core/sorted_list_engine_core_assert.svh */
// Assertion macros shared by the sorted list engine RTL.
`ifndef SORTED_LIST_ENGINE_CORE_ASSERT_SVH
`define SORTED_LIST_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SLE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted list engine check failed");

// Next-cycle implication, disabled during reset.
`define SLE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted list engine check failed");

`endif

/* rtl/core/sle_pkg.sv */
// Shared constants and types for the sorted list engine.
package sle_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic [1:0] KIND_INSERT     = 2'd0;
  localparam logic [1:0] KIND_REMOVE_ONE = 2'd1;
  localparam logic [1:0] KIND_REMOVE_ALL = 2'd2;
  localparam logic [1:0] KIND_DUMP       = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef logic signed [31:0] word_t;

  typedef struct packed {
    logic cmp;  // capture compare flags against the operand
    logic ins;  // open a slot at the first non-smaller cell
    logic del;  // close the gap at the first non-smaller cell
  } cell_cmd_t;

endpackage

/* rtl/core/sorted_list_engine_core.sv */
// Top level of the sorted list engine: control sequencer, cell chain and result register.
//
// Holds up to CAPACITY signed 32-bit values in ascending order in a chain of cells;
// each cell compares its value with the operand and shifts with its neighbors. An item
// is taken when in_ready is high, one at a time. With the result register free, insert
// and remove-first take a compare and then a shift across the chain; remove-all removes
// one copy per compare/shift pass until no match is left; dump sends one entry per result,
// paced by the result register. A refused insert, or a remove or dump on an empty list,
// answers without a pass through the chain. Results wait in an output register, so a
// stalled consumer holds the next item back only once that register is full.
`include "sorted_list_engine_core_assert.svh"

module sorted_list_engine_core import sle_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic [4:0]         out_entry_count,
  output logic [4:0]         out_removed_count,
  output logic signed [31:0] out_entry_value,
  output logic               out_last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMP   = 3'd1;
  localparam logic [2:0] S_APPLY = 3'd2;
  localparam logic [2:0] S_DONE  = 3'd3;
  localparam logic [2:0] S_DUMP  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       kind_r, kind_nxt;
  word_t            x_r, x_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] removed_r, removed_nxt;
  logic [1:0]       res_status_r, res_status_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [4:0]       out_entry_count_r, out_entry_count_nxt;
  logic [4:0]       out_removed_count_r, out_removed_count_nxt;
  word_t            out_entry_value_r, out_entry_value_nxt;
  logic             out_last_r, out_last_nxt;

  cell_cmd_t        cmd;
  word_t            cell_x;
  word_t            cell_val  [CAPACITY];
  logic             cell_lt   [CAPACITY];
  logic             cell_eq   [CAPACITY];
  logic             cell_occ  [CAPACITY];
  logic             left_lt_w [CAPACITY];
  word_t            left_val_w[CAPACITY];
  word_t            right_val_w[CAPACITY];
  logic             any_eq;
  logic             out_free;
  logic             finish;
  logic             dump_last;

  assign in_ready = (state_r == S_IDLE);
  assign cell_x   = (state_r == S_IDLE) ? in_value : x_r;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    any_eq = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      any_eq         = any_eq | cell_eq[i];
      left_lt_w[i]   = (i == 0) ? 1'b1 : cell_lt[(i == 0) ? 0 : i - 1];
      left_val_w[i]  = cell_val[(i == 0) ? 0 : i - 1];
      right_val_w[i] = cell_val[(i == CAPACITY - 1) ? i : i + 1];
    end
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      assign cell_occ[g] = (CNT_W'(g) < count_r);
      sle_cell u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .x        (cell_x),
        .occ      (cell_occ[g]),
        .left_lt  (left_lt_w[g]),
        .left_val (left_val_w[g]),
        .right_val(right_val_w[g]),
        .val      (cell_val[g]),
        .lt       (cell_lt[g]),
        .eq       (cell_eq[g])
      );
    end
  endgenerate

  assign dump_last = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  always_comb begin
    state_nxt             = state_r;
    kind_nxt              = kind_r;
    x_nxt                 = x_r;
    count_nxt             = count_r;
    removed_nxt           = removed_r;
    res_status_nxt        = res_status_r;
    idx_nxt               = idx_r;
    cmd                   = '0;
    finish                = 1'b0;
    out_valid_nxt         = out_valid_r && !out_ready;
    out_status_nxt        = out_status_r;
    out_entry_count_nxt   = out_entry_count_r;
    out_removed_count_nxt = out_removed_count_r;
    out_entry_value_nxt   = out_entry_value_r;
    out_last_nxt          = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt    = in_kind;
          x_nxt       = in_value;
          removed_nxt = '0;
          idx_nxt     = '0;
          cmd.cmp     = 1'b1;
          case (in_kind)
            KIND_INSERT: begin
              if (count_r >= CNT_W'(CAPACITY)) begin
                res_status_nxt = ST_FULL;
                finish         = 1'b1;
              end else begin
                state_nxt = S_APPLY;
              end
            end
            KIND_REMOVE_ONE, KIND_REMOVE_ALL: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
                finish         = 1'b1;
              end else begin
                state_nxt = S_APPLY;
              end
            end
            KIND_DUMP: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
                finish         = 1'b1;
              end else begin
                state_nxt = S_DUMP;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (kind_r == KIND_INSERT) begin
          cmd.ins        = 1'b1;
          count_nxt      = count_r + CNT_W'(1);
          res_status_nxt = ST_OK;
          finish         = 1'b1;
        end else if (any_eq) begin
          cmd.del     = 1'b1;
          count_nxt   = count_r - CNT_W'(1);
          removed_nxt = removed_r + CNT_W'(1);
          if (kind_r == KIND_REMOVE_ALL) begin
            state_nxt = S_CMP;
          end else begin
            res_status_nxt = ST_OK;
            finish         = 1'b1;
          end
        end else begin
          res_status_nxt = (removed_r != '0) ? ST_OK : ST_NOT_FOUND;
          finish         = 1'b1;
        end
      end
      S_DONE: begin
        finish = 1'b1;
      end
      S_DUMP: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_status_nxt        = ST_OK;
          out_entry_count_nxt   = 5'(count_r);
          out_removed_count_nxt = '0;
          out_entry_value_nxt   = cell_val[idx_r];
          out_last_nxt          = dump_last;
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // single-result operations end here; park in S_DONE while the output is occupied
    if (finish) begin
      if (out_free) begin
        out_valid_nxt         = 1'b1;
        out_status_nxt        = res_status_nxt;
        out_entry_count_nxt   = 5'(count_nxt);
        out_removed_count_nxt = 5'(removed_nxt);
        out_entry_value_nxt   = '0;
        out_last_nxt          = 1'b1;
        state_nxt             = S_IDLE;
      end else begin
        state_nxt = S_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r              <= kind_nxt;
    x_r                 <= x_nxt;
    removed_r           <= removed_nxt;
    res_status_r        <= res_status_nxt;
    idx_r               <= idx_nxt;
    out_status_r        <= out_status_nxt;
    out_entry_count_r   <= out_entry_count_nxt;
    out_removed_count_r <= out_removed_count_nxt;
    out_entry_value_r   <= out_entry_value_nxt;
    out_last_r          <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_entry_count   = out_entry_count_r;
  assign out_removed_count = out_removed_count_r;
  assign out_entry_value   = out_entry_value_r;
  assign out_last          = out_last_r;

  // with the list neither empty nor full, every operation needs the chain, so in_ready drops after acceptance
  `SLE_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(CAPACITY))
  `SLE_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready && (count_r != '0) && (count_r != CNT_W'(CAPACITY)), !in_ready)
  `SLE_ASSERT_NEXT(a_insert_grows, (state_r == S_APPLY) && (kind_r == KIND_INSERT),
                   count_r == $past(count_r) + CNT_W'(1))
  `SLE_ASSERT_IMP(a_dump_in_range, state_r == S_DUMP, CNT_W'(idx_r) < count_r)

endmodule

/* rtl/core/sle_cell.sv */
// One storage cell of the sorted chain: value, compare flags and neighbor shifting.
module sle_cell import sle_pkg::*; (
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  word_t     x,
  input  logic      occ,
  input  logic      left_lt,
  input  word_t     left_val,
  input  word_t     right_val,
  output word_t     val,
  output logic      lt,
  output logic      eq
);

  word_t val_r, val_nxt;
  logic  lt_r, lt_nxt;
  logic  eq_r, eq_nxt;

  always_comb begin
    val_nxt = val_r;
    lt_nxt  = lt_r;
    eq_nxt  = eq_r;
    if (cmd.cmp) begin
      lt_nxt = occ && (val_r < x);
      eq_nxt = occ && (val_r == x);
    end
    // cells below the operand keep their value; the rest move up or down by one
    if (cmd.ins && !lt_r) begin
      val_nxt = left_lt ? x : left_val;
    end
    if (cmd.del && !lt_r) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    lt_r  <= lt_nxt;
    eq_r  <= eq_nxt;
  end

  assign val = val_r;
  assign lt  = lt_r;
  assign eq  = eq_r;

endmodule
